// ===== hw/rtl/cidba_pkg.sv =====
// Shared types and constants of the context id bitmap allocator.
package cidba_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [31:0] WORD0_RESET = 32'hFFFF_FFF8;
    localparam logic [31:0] WORD_RESET  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        cmd;
        logic [15:0] freed_id;
    } t_in_item;

    typedef struct packed {
        logic [12:0] allocated_id;
        logic [1:0]  status;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic scan_start;
        logic scan_next;
        logic scan_hit;
        logic alloc_wr;
        logic free_start;
        logic free_wr;
        logic rep_range;
        logic rep_empty;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;
        logic hit;
        logic in_free;
        logic in_bad;
    } t_dp_sts;

endpackage

// ===== hw/rtl/cidba_dp.sv =====
// Datapath: free bitmap memory, word address counter, bit select and result register.
module cidba_dp #(
    parameter int MASK_WORDS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cidba_pkg::t_in_item  i_item,
    input  cidba_pkg::t_dp_cmd   i_cmd,
    output cidba_pkg::t_dp_sts   o_sts,
    output logic                 o_done,
    output cidba_pkg::t_out_item o_result
);

    localparam int AW = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;

    logic [31:0]          mem [MASK_WORDS];
    logic [31:0]          r_rd_data;
    logic [31:0]          r_wdata;
    logic [AW-1:0]        r_addr;
    logic [AW-1:0]        n_addr;
    logic [4:0]           r_bit;
    logic                 r_done;
    cidba_pkg::t_out_item r_result;

    logic [AW+8:0]        in_word;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;
    logic [4:0]           top;
    logic [AW+19:0]       id_full;

    // Position of the highest set bit of a nonzero word
    function automatic logic [4:0] top_bit(input logic [31:0] v);
        logic [31:0] w;
        logic [31:0] t;
        logic [4:0]  pos;
        w   = v;
        pos = 5'd0;
        t = w & 32'hFFFF_0000;
        if (t != 32'd0) begin
            pos = pos + 5'd16;
            w   = t;
        end
        t = w & 32'hFF00_FF00;
        if (t != 32'd0) begin
            pos = pos + 5'd8;
            w   = t;
        end
        t = w & 32'hF0F0_F0F0;
        if (t != 32'd0) begin
            pos = pos + 5'd4;
            w   = t;
        end
        t = w & 32'hCCCC_CCCC;
        if (t != 32'd0) begin
            pos = pos + 5'd2;
            w   = t;
        end
        if ((w & 32'hAAAA_AAAA) != 32'd0) begin
            pos = pos + 5'd1;
        end
        return pos;
    endfunction

    assign in_word = {{AW{1'b0}}, i_item.freed_id[15:7]};
    assign top     = top_bit(r_rd_data);
    assign id_full = {13'd0, r_addr, r_bit, 2'b00};

    assign o_sts.last    = (r_addr == AW'(MASK_WORDS - 1));
    assign o_sts.hit     = (r_rd_data != 32'd0);
    assign o_sts.in_free = (i_item.cmd == cidba_pkg::CMD_FREE);
    assign o_sts.in_bad  = (in_word >= (AW+9)'(MASK_WORDS));

    always_comb begin
        n_addr  = r_addr;
        rd_en   = 1'b0;
        rd_addr = r_addr;
        priority if (i_cmd.scan_start) begin
            n_addr  = '0;
            rd_en   = 1'b1;
            rd_addr = '0;
        end else if (i_cmd.scan_next || i_cmd.clr_wr) begin
            n_addr  = r_addr + AW'(1);
            rd_en   = i_cmd.scan_next;
            rd_addr = n_addr;
        end else if (i_cmd.free_start) begin
            n_addr  = in_word[AW-1:0];
            rd_en   = 1'b1;
            rd_addr = in_word[AW-1:0];
        end else begin
            n_addr = r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (i_cmd.clr_wr) begin
            mem[r_addr] <= (r_addr == '0) ? cidba_pkg::WORD0_RESET : cidba_pkg::WORD_RESET;
        end else if (i_cmd.alloc_wr) begin
            mem[r_addr] <= r_wdata;
        end else if (i_cmd.free_wr) begin
            mem[r_addr] <= r_rd_data | (32'd1 << r_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else begin
            r_addr <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.free_start) begin
            r_bit <= i_item.freed_id[6:2];
        end else if (i_cmd.scan_hit) begin
            r_bit   <= top;
            r_wdata <= r_rd_data & ~(32'd1 << top);
        end
    end

    // Result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.alloc_wr | i_cmd.free_wr | i_cmd.rep_range | i_cmd.rep_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.alloc_wr) begin
            r_result.allocated_id <= id_full[12:0];
            r_result.status       <= cidba_pkg::ST_OK;
        end else if (i_cmd.free_wr) begin
            r_result.allocated_id <= 13'd0;
            r_result.status       <= cidba_pkg::ST_OK;
        end else if (i_cmd.rep_range) begin
            r_result.allocated_id <= 13'd0;
            r_result.status       <= cidba_pkg::ST_RANGE;
        end else if (i_cmd.rep_empty) begin
            r_result.allocated_id <= 13'd0;
            r_result.status       <= cidba_pkg::ST_EMPTY;
        end else begin
            r_result <= r_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/cidba_ctrl.sv =====
// Controller state machine: clearing pass, word scan and read-modify-write sequencing.
module cidba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  cidba_pkg::t_dp_sts i_sts,
    output cidba_pkg::t_dp_cmd o_cmd,
    output logic               o_busy
);

    typedef enum logic [4:0] {
        S_CLEAR    = 5'b00001,
        S_IDLE     = 5'b00010,
        S_SCAN     = 5'b00100,
        S_ALLOC_WR = 5'b01000,
        S_FREE_WR  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (!i_sts.in_free) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end else if (i_sts.in_bad) begin
                        o_cmd.rep_range = 1'b1;
                    end else begin
                        o_cmd.free_start = 1'b1;
                        n_state          = S_FREE_WR;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state        = S_ALLOC_WR;
                end else if (i_sts.last) begin
                    o_cmd.rep_empty = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_ALLOC_WR: begin
                o_cmd.alloc_wr = 1'b1;
                n_state        = S_IDLE;
            end
            S_FREE_WR: begin
                o_cmd.free_wr = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/context_id_bitmap_allocator.sv =====
// Top level of the context id bitmap allocator.
//
//  channel  | handshake        | payload
//  ---------+------------------+----------------------------------
//  command  | start / busy     | i_item   (cmd, freed_id)
//  result   | o_done (strobe)  | o_result (allocated_id, status)
//
// Allocate: word 0 is read, words are examined in order (up to MASK_WORDS),
// and the first word with a free bit is written back. Free: the addressed
// word is read, then written back; an out of range free needs no memory
// access. The result beat follows in the cycle after the last step. After
// reset a clearing pass writes MASK_WORDS words, one per cycle, with busy
// high. The receiver cannot stall; each result is shown for one cycle.
module context_id_bitmap_allocator #(
    parameter int MASK_WORDS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cidba_pkg::t_in_item  i_item,
    output logic                 o_done,
    output cidba_pkg::t_out_item o_result
);

    cidba_pkg::t_dp_cmd dp_cmd;
    cidba_pkg::t_dp_sts dp_sts;

    cidba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    cidba_dp #(
        .MASK_WORDS (MASK_WORDS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .o_sts    (dp_sts),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the context id bitmap allocator.
module tb;

    localparam int MAP_WORDS  = 64;
    localparam int MAX_REPORT = 10;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start   = 1'b0;
    cidba_pkg::t_in_item  i_item  = '0;
    logic                 busy;
    logic                 o_done;
    cidba_pkg::t_out_item o_result;

    logic [31:0]          free_bits [MAP_WORDS];
    cidba_pkg::t_out_item pending_results [$];
    logic [15:0]          held_ids [$];
    int                   mismatch_cnt = 0;
    bit                   steady = 1'b0;

    context_id_bitmap_allocator #(
        .MASK_WORDS (MAP_WORDS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one command to the local copy of the bitmap and return the answer.
    function automatic cidba_pkg::t_out_item predict_ctx_op(input cidba_pkg::t_in_item it);
        cidba_pkg::t_out_item r;
        int                   w;
        int                   b;
        int                   id;
        logic [13:0]          slot;
        r = '0;
        r.status = cidba_pkg::ST_OK;
        if (it.cmd == cidba_pkg::CMD_ALLOC) begin
            w = 0;
            while (w < MAP_WORDS && free_bits[w] == '0)
                w++;
            if (w == MAP_WORDS) begin
                r.status = cidba_pkg::ST_EMPTY;
            end else begin
                b = 31;
                while (!free_bits[w][b])
                    b--;
                free_bits[w][b] = 1'b0;
                id = 4 * (32 * w + b);
                r.allocated_id = id[12:0];
            end
        end else begin
            slot = it.freed_id[15:2];
            if (int'(slot[13:5]) >= MAP_WORDS)
                r.status = cidba_pkg::ST_RANGE;
            else
                free_bits[slot[13:5]][slot[4:0]] = 1'b1;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input cidba_pkg::t_out_item want,
                                 input cidba_pkg::t_out_item got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORT)
            $display("%0t: %s: expected id %0d status %0d, got id %0d status %0d", $realtime,
                     what, want.allocated_id, want.status, got.allocated_id, got.status);
    endtask

    // Send one command beat; hold it until the block takes it.
    task automatic send_cmd(input cidba_pkg::t_in_item it,
                            output cidba_pkg::t_out_item pred);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = predict_ctx_op(it);
        pending_results.push_back(pred);
        if (it.cmd == cidba_pkg::CMD_ALLOC && pred.status == cidba_pkg::ST_OK)
            held_ids.push_back({3'b000, pred.allocated_id});
    endtask

    task automatic do_alloc(output cidba_pkg::t_out_item r);
        cidba_pkg::t_in_item it;
        it.cmd      = cidba_pkg::CMD_ALLOC;
        it.freed_id = 16'($urandom);
        send_cmd(it, r);
    endtask

    task automatic do_free(input logic [15:0] id);
        cidba_pkg::t_in_item  it;
        cidba_pkg::t_out_item r;
        it.cmd      = cidba_pkg::CMD_FREE;
        it.freed_id = id;
        send_cmd(it, r);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0)
                note_mismatch("unexpected result", '0, o_result);
            else if (o_result !== pending_results[0])
                note_mismatch("result mismatch", pending_results[0], o_result);
            if (pending_results.size() != 0)
                void'(pending_results.pop_front());
        end
    end

    task automatic test_directed();
        cidba_pkg::t_out_item r;
        do_alloc(r);            // top bit of word 0
        do_alloc(r);
        do_free(16'd124);
        do_alloc(r);
        do_free(16'd0);         // lowest id, taken at reset
        do_free(16'd0);         // double free
        do_free(16'd7);         // low bits dropped
        do_free(16'd2);
        do_free(16'd8191);      // last id of last word, already free
        do_free(16'd8192);      // first word past the map
        do_free(16'hFFFF);
        do_free(16'h8000);
        do_free(16'h4000);
        do_alloc(r);
        do_alloc(r);
        do_alloc(r);
        do_alloc(r);
    endtask

    // Take every id, then probe the empty map and the lone lowest id.
    task automatic test_drain();
        cidba_pkg::t_out_item r;
        int                   n;
        n = 0;
        do begin
            if (n % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            do_alloc(r);
            n++;
        end while (r.status != cidba_pkg::ST_EMPTY);
        steady = 1'b0;
        do_alloc(r);
        do_free(16'd0);
        do_alloc(r);
        do_alloc(r);
        do_free(16'd8188);
        do_alloc(r);
        do_alloc(r);
    endtask

    task automatic test_random();
        cidba_pkg::t_out_item r;
        int                   alloc_pct;
        int                   kind;
        int                   k;
        logic [15:0]          id;
        alloc_pct = 50;
        for (int i = 0; i < 200; i++) begin
            if (i % 50 == 0) begin
                steady = ($urandom_range(0, 4) == 0);
                case ($urandom_range(0, 2))
                    0: alloc_pct = 20;
                    1: alloc_pct = 50;
                    default: alloc_pct = 80;
                endcase
            end
            if ($urandom_range(0, 99) < alloc_pct) begin
                do_alloc(r);
            end else begin
                kind = $urandom_range(0, 9);
                if (kind < 7 && held_ids.size() != 0) begin
                    k  = $urandom_range(0, held_ids.size() - 1);
                    id = held_ids[k];
                    held_ids.delete(k);
                    if (kind == 0)
                        id[1:0] = 2'($urandom);
                end else if (kind < 9) begin
                    id = 16'($urandom_range(0, 8191));
                end else begin
                    id = 16'($urandom);
                end
                do_free(id);
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        free_bits[0] = cidba_pkg::WORD0_RESET;
        for (int w = 1; w < MAP_WORDS; w++)
            free_bits[w] = cidba_pkg::WORD_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_drain();
        test_random();
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (MAP_WORDS + 8) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cidba_pkg.sv
hw/rtl/cidba_dp.sv
hw/rtl/cidba_ctrl.sv
hw/rtl/context_id_bitmap_allocator.sv
test/tb.sv
